@@ design/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list insert block
// pool size, field widths, mode and status codes, controller/datapath structs
// ----------------------------------------------------------------------------
package sli_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LINK_W   = CNT_W;

	localparam int ADDR_W   = 64;
	localparam int TYPE_W   = 8;
	localparam int NAME_W   = 32;
	localparam int SLOT_W   = 6;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	// request modes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// kind of result loaded into the output register
	localparam logic [1:0] RES_INSERT = 2'd0;
	localparam logic [1:0] RES_FULL   = 2'd1;
	localparam logic [1:0] RES_EMPTY  = 2'd2;
	localparam logic [1:0] RES_ENTRY  = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [TYPE_W-1:0] typ;
		logic [NAME_W-1:0] name_ref;
		logic [NAME_W-1:0] name_len;
	} sli_entry_t;

	typedef struct packed {
		logic       take;       // latch the incoming entry
		logic       ent_we;     // write the new entry into the pool
		logic       cur_init;   // start a walk at the head
		logic       rd_en;      // read the pool at the walk position
		logic       walk_adv;   // follow the link just read
		logic       link_we;    // write one link
		logic       link_sel;   // 0: link of new slot, 1: link of predecessor
		logic       head_set;   // new slot becomes the head
		logic       cnt_inc;    // one more slot taken
		logic       list_clear; // empty the list
		logic       res_load;   // load the output register
		logic [1:0] res_kind;
	} sli_cmd_t;

	typedef struct packed {
		logic used_zero;
		logic used_full;
		logic key_lt;     // new address below the one just read
		logic link_end;   // link just read ends the list
		logic step_last;  // this step reaches the entry count
		logic prev_valid;
	} sli_sts_t;

endpackage

@@ design/sli_in_if.sv @@
// ----------------------------------------------------------------------------
// sli_in_if: request channel
// valid/ready handshake carrying mode and the entry to insert
// ----------------------------------------------------------------------------
interface sli_in_if
	import sli_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ADDR_W-1:0]   address;
	logic [TYPE_W-1:0]   sym_type;
	logic [NAME_W-1:0]   name_handle;
	logic [NAME_W-1:0]   name_length;

	modport source (output valid, mode, address, sym_type, name_handle, name_length,
		input ready);
	modport sink (input valid, mode, address, sym_type, name_handle, name_length,
		output ready);
endinterface

@@ design/sli_out_if.sv @@
// ----------------------------------------------------------------------------
// sli_out_if: result channel
// valid/ready handshake carrying status, slot and the emitted entry
// ----------------------------------------------------------------------------
interface sli_out_if
	import sli_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [ADDR_W-1:0]   out_address;
	logic [TYPE_W-1:0]   out_type;
	logic [NAME_W-1:0]   out_name_handle;
	logic [NAME_W-1:0]   out_name_length;
	logic                last;

	modport source (output valid, status, slot, out_address, out_type, out_name_handle,
		out_name_length, last, input ready);
	modport sink (input valid, status, slot, out_address, out_type, out_name_handle,
		out_name_length, last, output ready);
endinterface

@@ design/sli_datapath.sv @@
// ----------------------------------------------------------------------------
// sli_datapath: entry pool, link memory, walk registers and result register
// executes the controller's commands one cycle at a time
// ----------------------------------------------------------------------------
module sli_datapath
	import sli_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  sli_cmd_t            cmd,
	output sli_sts_t            sts,
	input  logic [ADDR_W-1:0]   in_address,
	input  logic [TYPE_W-1:0]   in_sym_type,
	input  logic [NAME_W-1:0]   in_name_handle,
	input  logic [NAME_W-1:0]   in_name_length,
	output logic [STATUS_W-1:0] res_status,
	output logic [SLOT_W-1:0]   res_slot,
	output logic [ADDR_W-1:0]   res_address,
	output logic [TYPE_W-1:0]   res_type,
	output logic [NAME_W-1:0]   res_name_handle,
	output logic [NAME_W-1:0]   res_name_length,
	output logic                res_last
);

	sli_entry_t          entry_mem [CAPACITY];
	logic [LINK_W-1:0]   link_mem [CAPACITY];

	sli_entry_t          key_q;
	sli_entry_t          rd_entry_q;
	logic [LINK_W-1:0]   rd_link_q;
	logic [LINK_W-1:0]   cur_q;
	logic [IDX_W-1:0]    prev_q;
	logic                prev_valid_q;
	logic [CNT_W-1:0]    step_q;
	logic [CNT_W-1:0]    used_q;
	logic [IDX_W-1:0]    head_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	sli_entry_t          res_entry_q;
	logic                res_last_q;

	logic [IDX_W-1:0]    new_slot;
	logic [IDX_W-1:0]    rd_idx;
	logic [IDX_W-1:0]    link_wr_idx;
	logic [LINK_W-1:0]   link_wr_data;
	logic [CNT_W-1:0]    step_next;

	assign new_slot     = used_q[IDX_W-1:0];
	assign rd_idx       = cur_q[IDX_W-1:0];
	assign link_wr_idx  = cmd.link_sel ? prev_q : new_slot;
	assign link_wr_data = cmd.link_sel ? LINK_W'(used_q) : cur_q;
	assign step_next    = CNT_W'(step_q + CNT_W'(1));

	assign sts.used_zero  = (used_q == '0);
	assign sts.used_full  = (used_q == CNT_W'(CAPACITY));
	assign sts.key_lt     = (key_q.addr < rd_entry_q.addr);
	assign sts.link_end   = (rd_link_q >= LINK_W'(CAPACITY));
	assign sts.step_last  = (step_next == used_q);
	assign sts.prev_valid = prev_valid_q;

	// payload latch, no reset
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			key_q.addr     <= in_address;
			key_q.typ      <= in_sym_type;
			key_q.name_ref <= in_name_handle;
			key_q.name_len <= in_name_length;
		end
	end

	// pool memories
	always_ff @(posedge clk) begin
		if (cmd.ent_we) begin
			entry_mem[new_slot] <= key_q;
		end
		if (cmd.rd_en) begin
			rd_entry_q <= entry_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.link_we) begin
			link_mem[link_wr_idx] <= link_wr_data;
		end
		if (cmd.rd_en) begin
			rd_link_q <= link_mem[rd_idx];
		end
	end

	// walk and list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			step_q       <= '0;
			used_q       <= '0;
			head_q       <= '0;
		end else begin
			if (cmd.cur_init) begin
				cur_q        <= (used_q == '0) ? LINK_W'(CAPACITY) : LINK_W'(head_q);
				prev_valid_q <= 1'b0;
				step_q       <= '0;
			end else if (cmd.walk_adv) begin
				cur_q        <= rd_link_q;
				prev_q       <= rd_idx;
				prev_valid_q <= 1'b1;
				step_q       <= step_next;
			end
			if (cmd.list_clear) begin
				used_q <= '0;
				head_q <= '0;
			end else begin
				if (cmd.head_set) begin
					head_q <= new_slot;
				end
				if (cmd.cnt_inc) begin
					used_q <= CNT_W'(used_q + CNT_W'(1));
				end
			end
		end
	end

	// result register, payload only
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_kind)
				RES_INSERT: begin
					res_status_q <= ST_OK;
					res_slot_q   <= SLOT_W'(new_slot);
					res_entry_q  <= '0;
					res_last_q   <= 1'b1;
				end
				RES_FULL: begin
					res_status_q <= ST_FULL;
					res_slot_q   <= '0;
					res_entry_q  <= '0;
					res_last_q   <= 1'b1;
				end
				RES_EMPTY: begin
					res_status_q <= ST_EMPTY;
					res_slot_q   <= '0;
					res_entry_q  <= '0;
					res_last_q   <= 1'b1;
				end
				RES_ENTRY: begin
					res_status_q <= ST_OK;
					res_slot_q   <= SLOT_W'(rd_idx);
					res_entry_q  <= rd_entry_q;
					res_last_q   <= sts.link_end || sts.step_last;
				end
				default: begin
					res_status_q <= ST_OK;
					res_slot_q   <= '0;
					res_entry_q  <= '0;
					res_last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign res_status      = res_status_q;
	assign res_slot        = res_slot_q;
	assign res_address     = res_entry_q.addr;
	assign res_type        = res_entry_q.typ;
	assign res_name_handle = res_entry_q.name_ref;
	assign res_name_length = res_entry_q.name_len;
	assign res_last        = res_last_q;

	// walk only touches slots that hold entries
	a_rd_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (cur_q < LINK_W'(used_q)))
		else $error("pool read outside the taken slots");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (step_q < used_q))
		else $error("walk longer than the list");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(CAPACITY))
		else $error("entry count above pool size");

endmodule

@@ design/sli_controller.sv @@
// ----------------------------------------------------------------------------
// sli_controller: sequencer for insert, read out and clear
// drives datapath commands and both channel handshakes
// ----------------------------------------------------------------------------
module sli_controller
	import sli_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MODE_W-1:0] in_mode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sli_cmd_t          cmd,
	input  sli_sts_t          sts
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_FULL     = 4'd1;
	localparam logic [3:0] S_EMPTY    = 4'd2;
	localparam logic [3:0] S_INS_WR   = 4'd3;
	localparam logic [3:0] S_INS_RD   = 4'd4;
	localparam logic [3:0] S_INS_CMP  = 4'd5;
	localparam logic [3:0] S_INS_LNK  = 4'd6;
	localparam logic [3:0] S_INS_LNK2 = 4'd7;
	localparam logic [3:0] S_INS_RES  = 4'd8;
	localparam logic [3:0] S_RD_RD    = 4'd9;
	localparam logic [3:0] S_RD_EMIT  = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (in_mode == MODE_INSERT) begin
						if (sts.used_full) begin
							state_d = S_FULL;
						end else begin
							cmd.take = 1'b1;
							state_d  = S_INS_WR;
						end
					end else if (in_mode == MODE_READ) begin
						if (sts.used_zero) begin
							state_d = S_EMPTY;
						end else begin
							cmd.cur_init = 1'b1;
							state_d      = S_RD_RD;
						end
					end else if (in_mode == MODE_CLEAR) begin
						cmd.list_clear = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FULL: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_FULL;
					state_d      = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_EMPTY;
					state_d      = S_IDLE;
				end
			end
			S_INS_WR: begin
				cmd.ent_we   = 1'b1;
				cmd.cur_init = 1'b1;
				state_d      = sts.used_zero ? S_INS_LNK : S_INS_RD;
			end
			S_INS_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_INS_CMP;
			end
			S_INS_CMP: begin
				if (sts.key_lt) begin
					state_d = S_INS_LNK;
				end else begin
					cmd.walk_adv = 1'b1;
					state_d      = (sts.link_end || sts.step_last) ? S_INS_LNK : S_INS_RD;
				end
			end
			S_INS_LNK: begin
				cmd.link_we  = 1'b1;
				cmd.link_sel = 1'b0;
				if (sts.prev_valid) begin
					state_d = S_INS_LNK2;
				end else begin
					cmd.head_set = 1'b1;
					state_d      = S_INS_RES;
				end
			end
			S_INS_LNK2: begin
				cmd.link_we  = 1'b1;
				cmd.link_sel = 1'b1;
				state_d      = S_INS_RES;
			end
			S_INS_RES: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_INSERT;
					cmd.cnt_inc  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_RD_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RD_EMIT;
			end
			S_RD_EMIT: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ENTRY;
					if (sts.link_end || sts.step_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_adv = 1'b1;
						state_d      = S_RD_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while pending");

endmodule

@@ design/sorted_list_insert_by_address.sv @@
// insert: the entry is written, then list entries are read and compared in turn until the place
// is found, then the new slot's link is written, plus the predecessor link when the new entry is
// not the head, then the result; full and empty status follow acceptance, clear acts at acceptance
// read out: a pool read then an emit per entry; one request at a time, a new one taken only in idle
// reset: arst_n empties the list at once; pool contents stay undefined, no clearing pass
// ----------------------------------------------------------------------------
// sorted_list_insert_by_address: pool of symbol entries kept as a linked list
// sorted by ascending address, with insert, sorted read out and clear
// ----------------------------------------------------------------------------
module sorted_list_insert_by_address
	import sli_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	sli_in_if.sink    in_ch,
	sli_out_if.source out_ch
);

	// controller to datapath command word and status back
	sli_cmd_t cmd;
	sli_sts_t sts;

	// the controller owns both handshakes; a request is taken only in idle,
	// while a finished result may still sit in the output register
	sli_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_mode   (in_ch.mode),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// the datapath holds the pool, links, walk registers and the result
	// register that feeds the output transaction
	sli_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_address      (in_ch.address),
		.in_sym_type     (in_ch.sym_type),
		.in_name_handle  (in_ch.name_handle),
		.in_name_length  (in_ch.name_length),
		.res_status      (out_ch.status),
		.res_slot        (out_ch.slot),
		.res_address     (out_ch.out_address),
		.res_type        (out_ch.out_type),
		.res_name_handle (out_ch.out_name_handle),
		.res_name_length (out_ch.out_name_length),
		.res_last        (out_ch.last)
	);

endmodule
